// ===== rtl/ucng_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character n-gram emitter: shared package
// Command format passed from the byte front end to the gram back end, and
// the UTF-8 lead byte decoder.
// ----------------------------------------------------------------------------
package ucng_pkg;

    localparam int CHAR_W      = 32;
    localparam int NBYTES_W    = 3;
    localparam int GRAM_W      = 4;
    // Wide enough for an emit count up to the largest supported window (16).
    localparam int EMIT_CNT_W  = 5;
    localparam logic [GRAM_W-1:0] GRAM_LENGTH_RESET = 4'd3;

    // Register byte offsets on the configuration port.
    localparam logic [2:0] ADDR_GRAM_LENGTH = 3'd0;

    typedef struct packed {
        logic                  push;      // a finished character enters the window
        logic [CHAR_W-1:0]     value;
        logic [NBYTES_W-1:0]   nbytes;
        logic [EMIT_CNT_W-1:0] emit_cnt;  // characters to emit after the push, 0 = none
        logic                  is_short;
    } t_cmd;

    // Number of bytes a character needs, judged from its lead byte.
    // Zero marks a stray continuation byte.
    function automatic logic [NBYTES_W-1:0] lead_length(input logic [7:0] b);
        logic [NBYTES_W-1:0] need;
        need = 3'd0;
        if (b[7] == 1'b0) begin
            need = 3'd1;
        end else if (b[7:4] == 4'hF) begin
            need = 3'd4;
        end else if (b[7:4] == 4'hE) begin
            need = 3'd3;
        end else if (b[7:6] == 2'b11) begin
            need = 3'd2;
        end
        return need;
    endfunction

endpackage

// ===== rtl/ucng_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character n-gram emitter: byte front end
// Assembles characters from bytes, counts characters in the word and decides
// how many characters of the window each byte makes the back end emit.
// ----------------------------------------------------------------------------
module ucng_front #(
    parameter int MAX_GRAM_LENGTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_word_byte,
    input  logic                        i_end_of_word,
    input  logic [ucng_pkg::GRAM_W-1:0] i_gram_length,
    output logic                        o_cmd_valid,
    output ucng_pkg::t_cmd              o_cmd,
    input  logic                        i_cmd_full
);
    import ucng_pkg::*;

    localparam int CW = $clog2(MAX_GRAM_LENGTH + 1);
    localparam logic [EMIT_CNT_W-1:0] MAX_E = EMIT_CNT_W'(MAX_GRAM_LENGTH);
    localparam logic [CW-1:0]         MAX_C = CW'(MAX_GRAM_LENGTH);

    logic [CHAR_W-1:0]   r_partial,  n_partial;
    logic [NBYTES_W-1:0] r_gathered, n_gathered;
    logic [NBYTES_W-1:0] r_expected, n_expected;
    logic [CW-1:0]       r_chars,    n_chars;

    logic                  accept;
    logic                  done;
    logic [NBYTES_W-1:0]   need;
    logic [EMIT_CNT_W-1:0] gram5;
    logic [EMIT_CNT_W-1:0] len5;
    logic [CW-1:0]         len_c;
    logic [CW-1:0]         cnt_after;
    logic [CHAR_W-1:0]     asm_value;
    logic [NBYTES_W-1:0]   asm_nbytes;
    t_cmd                  cmd;

    assign o_stall = i_cmd_full;
    assign accept  = i_valid && !i_cmd_full;
    assign need    = lead_length(i_word_byte);

    // Out-of-range lengths clamp to one and to the window depth.
    always_comb begin
        gram5 = {1'b0, i_gram_length};
        if (gram5 == '0) begin
            len5 = EMIT_CNT_W'(1);
        end else if (gram5 > MAX_E) begin
            len5 = MAX_E;
        end else begin
            len5 = gram5;
        end
        len_c = len5[CW-1:0];
    end

    always_comb begin
        n_partial  = r_partial;
        n_gathered = r_gathered;
        n_expected = r_expected;
        n_chars    = r_chars;
        done       = 1'b0;
        cnt_after  = r_chars;
        cmd        = '0;

        if (r_gathered != '0) begin
            asm_value  = {r_partial[CHAR_W-9:0], i_word_byte};
            asm_nbytes = r_gathered + NBYTES_W'(1);
            done       = (asm_nbytes >= r_expected);
            n_expected = r_expected;
        end else begin
            asm_value  = {24'd0, i_word_byte};
            asm_nbytes = (need != '0) ? NBYTES_W'(1) : '0;
            done       = (need == NBYTES_W'(1));
            n_expected = need;
        end
        // A word end closes a character in progress with the bytes it has.
        if (i_end_of_word && asm_nbytes != '0) begin
            done = 1'b1;
        end
        n_partial  = asm_value;
        n_gathered = asm_nbytes;

        cmd.value  = asm_value;
        cmd.nbytes = asm_nbytes;
        if (done) begin
            cmd.push   = 1'b1;
            cnt_after  = (r_chars < MAX_C) ? r_chars + CW'(1) : r_chars;
            n_chars    = cnt_after;
            n_partial  = '0;
            n_gathered = '0;
            n_expected = '0;
            if (cnt_after >= len_c) begin
                cmd.emit_cnt = len5;
            end
        end
        if (i_end_of_word) begin
            if (cnt_after != '0 && cnt_after < len_c) begin
                cmd.emit_cnt = EMIT_CNT_W'(cnt_after);
                cmd.is_short = 1'b1;
            end
            n_chars    = '0;
            n_partial  = '0;
            n_gathered = '0;
            n_expected = '0;
        end
    end

    assign o_cmd_valid = accept && (cmd.push || cmd.emit_cnt != '0);
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_gathered <= '0;
            r_expected <= '0;
            r_chars    <= '0;
        end else if (accept) begin
            r_partial  <= n_partial;
            r_gathered <= n_gathered;
            r_expected <= n_expected;
            r_chars    <= n_chars;
        end
    end

endmodule

// ===== rtl/ucng_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character n-gram emitter: command queue
// Two-entry queue that lets the front end keep taking bytes while the back
// end is still sending a gram.
// ----------------------------------------------------------------------------
module ucng_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucng_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ucng_pkg::t_cmd o_data
);
    import ucng_pkg::*;

    t_cmd       r_data [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ucng_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character n-gram emitter: gram back end
// Holds the character window, applies each command's push and sends the
// requested characters one per transfer, oldest first.
// ----------------------------------------------------------------------------
module ucng_back #(
    parameter int MAX_GRAM_LENGTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  ucng_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ucng_pkg::CHAR_W-1:0]   o_char_value,
    output logic [ucng_pkg::NBYTES_W-1:0] o_char_bytes,
    output logic                          o_last_of_gram,
    output logic                          o_short_word
);
    import ucng_pkg::*;

    localparam int CW = $clog2(MAX_GRAM_LENGTH + 1);
    localparam int IW = (MAX_GRAM_LENGTH > 1) ? $clog2(MAX_GRAM_LENGTH) : 1;
    localparam logic [CW:0] MAX_X = (CW + 1)'(MAX_GRAM_LENGTH);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [CHAR_W-1:0]   r_win_val [MAX_GRAM_LENGTH];
    logic [NBYTES_W-1:0] r_win_len [MAX_GRAM_LENGTH];
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_k, n_k;
    logic                r_short, n_short;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_out_value, n_out_value;
    logic [NBYTES_W-1:0] r_out_bytes, n_out_bytes;
    logic                r_out_last, n_out_last;
    logic                r_out_short, n_out_short;

    logic          out_free;
    logic          pop;
    logic          shift;
    logic [CW:0]   idx_full;
    logic [IW-1:0] idx;
    logic          last;

    assign out_free = !r_out_valid || !i_stall;
    assign idx_full = MAX_X - {1'b0, r_cnt} + {1'b0, r_k};
    assign idx      = idx_full[IW-1:0];
    assign last     = (r_k == r_cnt - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_short     = r_short;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_bytes = r_out_bytes;
        n_out_last  = r_out_last;
        n_out_short = r_out_short;
        pop         = 1'b0;
        shift       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    pop   = 1'b1;
                    shift = i_cmd.push;
                    if (i_cmd.emit_cnt != '0) begin
                        n_state = ST_EMIT;
                        n_cnt   = i_cmd.emit_cnt[CW-1:0];
                        n_k     = '0;
                        n_short = i_cmd.is_short;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_win_val[idx];
                    n_out_bytes = r_win_len[idx];
                    n_out_last  = last;
                    n_out_short = r_short;
                    n_k         = r_k + CW'(1);
                    if (last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd_pop      = pop;
    assign o_valid        = r_out_valid;
    assign o_char_value   = r_out_value;
    assign o_char_bytes   = r_out_bytes;
    assign o_last_of_gram = r_out_last;
    assign o_short_word   = r_out_short;

    // The newest character sits at the top of the window.
    always_ff @(posedge i_clk) begin
        if (shift) begin
            for (int j = 0; j < MAX_GRAM_LENGTH - 1; j++) begin
                r_win_val[j] <= r_win_val[j+1];
                r_win_len[j] <= r_win_len[j+1];
            end
            r_win_val[MAX_GRAM_LENGTH-1] <= i_cmd.value;
            r_win_len[MAX_GRAM_LENGTH-1] <= i_cmd.nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_short     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_short     <= n_short;
        end
        r_out_value <= n_out_value;
        r_out_bytes <= n_out_bytes;
        r_out_last  <= n_out_last;
        r_out_short <= n_out_short;
    end

endmodule

// ===== rtl/utf8_char_ngram_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 character n-gram emitter
// Groups word bytes into UTF-8 characters and sends every character n-gram
// of each word, one character per transfer.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_word_byte, i_end_of_word
//   output    out        o_valid / i_stall   o_char_value, o_char_bytes,
//                                            o_last_of_gram, o_short_word
//   config    in         psel / penable      paddr, pwdata, prdata
//
// Bytes are taken while the byte front end is not stalling; it stalls only
// when the two-entry command queue is full. The back end pops one command
// while idle, then sends that command's characters one per transfer,
// holding each one while the output is stalled.
// Reset is synchronous and clears control state; the gram length returns to 3.
// A stall on the output holds the output register and backs up into the queue.
// ----------------------------------------------------------------------------
module utf8_char_ngram_emitter_unit #(
    parameter int MAX_GRAM_LENGTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_word_byte,
    input  logic                          i_end_of_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ucng_pkg::CHAR_W-1:0]   o_char_value,
    output logic [ucng_pkg::NBYTES_W-1:0] o_char_bytes,
    output logic                          o_last_of_gram,
    output logic                          o_short_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import ucng_pkg::*;

    logic [GRAM_W-1:0] r_gram_length;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              q_full;
    logic              q_valid;
    t_cmd              q_data;
    logic              q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GRAM_LENGTH) ? {28'd0, r_gram_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gram_length <= GRAM_LENGTH_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_GRAM_LENGTH) begin
            r_gram_length <= pwdata[GRAM_W-1:0];
        end
    end

    ucng_front #(
        .MAX_GRAM_LENGTH(MAX_GRAM_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_word_byte  (i_word_byte),
        .i_end_of_word(i_end_of_word),
        .i_gram_length(r_gram_length),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_full   (q_full)
    );

    ucng_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    ucng_back #(
        .MAX_GRAM_LENGTH(MAX_GRAM_LENGTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_data),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_value  (o_char_value),
        .o_char_bytes  (o_char_bytes),
        .o_last_of_gram(o_last_of_gram),
        .o_short_word  (o_short_word)
    );

endmodule
